### src/fdm_pkg.sv
// Shared constants for the floored divide/modulo pipeline.
package fdm_pkg;

    localparam int unsigned FDM_DATA_WIDTH   = 32;
    localparam int unsigned FDM_WIDTH_MIN    = 8;
    localparam int unsigned FDM_WIDTH_MAX    = 64;

endpackage

### src/floor_divide_modulo.sv
// Top level: pipelined floored signed division with non-negative modulo.
//
//  channel  | dir | tdata (low bit up)                 | tuser
//  ---------+-----+------------------------------------+-------------
//  s (in)   | in  | dividend[W], divisor[W-1], zero pad | -
//  m (out)  | out | quotient[W], remainder[W-1], pad    | zero_divisor
//
// One beat per cycle sustained while the output is not stalled; the stages are
// the entry stage, W division cells (a chain of one-bit restoring cells), exit stage.
// Reset is synchronous and active low; it clears only the valid bits.
// Each stage holds its beat while downstream stalls and fills its bubble
// otherwise, so input keeps flowing into bubbles while a result waits at the output.
module floor_divide_modulo #(
    parameter int unsigned DATA_WIDTH = fdm_pkg::FDM_DATA_WIDTH,
    localparam int unsigned TDATA_BITS = ((2 * DATA_WIDTH - 1 + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [TDATA_BITS-1:0] i_s_tdata,  // dividend, divisor, pad
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [TDATA_BITS-1:0] o_m_tdata,  // quotient, remainder, pad
    output logic                  o_m_tuser   // zero_divisor
);

    import fdm_pkg::*;

    localparam int unsigned W     = DATA_WIDTH;
    localparam int unsigned USED  = 2 * W - 1;
    localparam int unsigned PAD   = TDATA_BITS - USED;

    logic         c_valid [W+1];
    logic         c_ready [W+1];
    logic [W-2:0] c_rem   [W+1];
    logic [W-1:0] c_num   [W+1];
    logic [W-2:0] c_div   [W+1];
    logic         c_neg   [W+1];
    logic         c_zero  [W+1];
    logic [W-1:0] quotient;
    logic [W-2:0] remainder;
    logic [USED-1:0] unused_pad_chk;

    fdm_front #(.W(W)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_dividend (i_s_tdata[W-1:0]),
        .i_divisor  (i_s_tdata[USED-1:W]),
        .o_valid    (c_valid[0]),
        .i_ready    (c_ready[0]),
        .o_rem      (c_rem[0]),
        .o_num      (c_num[0]),
        .o_div      (c_div[0]),
        .o_neg      (c_neg[0]),
        .o_zero     (c_zero[0])
    );

    for (genvar k = 0; k < W; k++) begin : g_cell
        fdm_cell #(.W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_rem   (c_rem[k]),
            .i_num   (c_num[k]),
            .i_div   (c_div[k]),
            .i_neg   (c_neg[k]),
            .i_zero  (c_zero[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_num   (c_num[k+1]),
            .o_div   (c_div[k+1]),
            .o_neg   (c_neg[k+1]),
            .o_zero  (c_zero[k+1])
        );
    end

    fdm_back #(.W(W)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (c_valid[W]),
        .o_ready        (c_ready[W]),
        .i_rem          (c_rem[W]),
        .i_num          (c_num[W]),
        .i_div          (c_div[W]),
        .i_neg          (c_neg[W]),
        .i_zero         (c_zero[W]),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_quotient     (quotient),
        .o_remainder    (remainder),
        .o_zero_divisor (o_m_tuser)
    );

    assign unused_pad_chk = {remainder, quotient};

    if (PAD > 0) begin : g_pad
        assign o_m_tdata = {{PAD{1'b0}}, unused_pad_chk};
    end else begin : g_nopad
        assign o_m_tdata = unused_pad_chk;
    end

endmodule

### src/fdm_front.sv
// Entry stage: dividend magnitude, sign and zero-divisor detect.
module fdm_front #(
    parameter int unsigned W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_dividend,
    input  logic [W-2:0] i_divisor,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-2:0] o_rem,
    output logic [W-1:0] o_num,
    output logic [W-2:0] o_div,
    output logic         o_neg,
    output logic         o_zero
);

    logic         r_valid;
    logic [W-1:0] r_num;
    logic [W-2:0] r_div;
    logic         r_neg;
    logic         r_zero;
    logic         n_neg;
    logic [W-1:0] n_num;

    assign o_ready = !r_valid || i_ready;
    assign n_neg   = i_dividend[W-1];
    // magnitude of the most negative value still fits in W unsigned bits
    assign n_num   = n_neg ? (~i_dividend + {{(W-1){1'b0}}, 1'b1}) : i_dividend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_num  <= n_num;
            r_div  <= i_divisor;
            r_neg  <= n_neg;
            r_zero <= (i_divisor == '0);
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = '0;
    assign o_num   = r_num;
    assign o_div   = r_div;
    assign o_neg   = r_neg;
    assign o_zero  = r_zero;

endmodule

### src/fdm_cell.sv
// One restoring-division cell: resolves one quotient bit per beat.
module fdm_cell #(
    parameter int unsigned W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-2:0] i_rem,
    input  logic [W-1:0] i_num,
    input  logic [W-2:0] i_div,
    input  logic         i_neg,
    input  logic         i_zero,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-2:0] o_rem,
    output logic [W-1:0] o_num,
    output logic [W-2:0] o_div,
    output logic         o_neg,
    output logic         o_zero
);

    logic         r_valid;
    logic [W-2:0] r_rem;
    logic [W-1:0] r_num;
    logic [W-2:0] r_div;
    logic         r_neg;
    logic         r_zero;
    logic [W-1:0] trial;
    logic [W-2:0] diff;
    logic         fits;
    logic [W-2:0] n_rem;
    logic [W-1:0] n_num;

    assign o_ready = !r_valid || i_ready;

    // partial remainder shifted left, next dividend bit brought down
    assign trial = {i_rem, i_num[W-1]};
    // trial < 2*div, so when it fits the difference is below div
    assign diff  = trial[W-2:0] - i_div;
    assign fits  = (trial >= {1'b0, i_div});
    assign n_rem = fits ? diff : trial[W-2:0];
    // dividend bits leave at the top, quotient bits enter at the bottom
    assign n_num = {i_num[W-2:0], fits};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_rem  <= n_rem;
            r_num  <= n_num;
            r_div  <= i_div;
            r_neg  <= i_neg;
            r_zero <= i_zero;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_div   = r_div;
    assign o_neg   = r_neg;
    assign o_zero  = r_zero;

endmodule

### src/fdm_back.sv
// Exit stage: floor correction for negative dividends, zero result for a zero divisor, output register.
module fdm_back #(
    parameter int unsigned W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-2:0] i_rem,
    input  logic [W-1:0] i_num,
    input  logic [W-2:0] i_div,
    input  logic         i_neg,
    input  logic         i_zero,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_quotient,
    output logic [W-2:0] o_remainder,
    output logic         o_zero_divisor
);

    logic         r_valid;
    logic [W-1:0] r_quotient;
    logic [W-2:0] r_remainder;
    logic         r_zero;
    logic         fix;
    logic [W-1:0] n_quotient;
    logic [W-2:0] n_remainder;

    assign o_ready = !r_valid || i_ready;

    // negative dividend with nonzero remainder: q = -(qm+1) = ~qm, r = b - rm
    assign fix = i_neg && (i_rem != '0);

    always_comb begin
        if (i_zero) begin
            n_quotient  = '0;
            n_remainder = '0;
        end else if (fix) begin
            n_quotient  = ~i_num;
            n_remainder = i_div - i_rem;
        end else if (i_neg) begin
            n_quotient  = ~i_num + {{(W-1){1'b0}}, 1'b1};
            n_remainder = i_rem;
        end else begin
            n_quotient  = i_num;
            n_remainder = i_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_quotient  <= n_quotient;
            r_remainder <= n_remainder;
            r_zero      <= i_zero;
        end
    end

    assign o_valid        = r_valid;
    assign o_quotient     = r_quotient;
    assign o_remainder    = r_remainder;
    assign o_zero_divisor = r_zero;

endmodule
